// ===== design/hss_pkg.sv =====
// Shared types, constants and slot tables for the half-shell neighbor stencil.
package hss_pkg;

  localparam int unsigned MaxCellsPerAxis = 64;

  localparam int unsigned AxisW  = 7;   // grid size registers
  localparam int unsigned CoordW = 6;   // cell coordinates
  localparam int unsigned IndexW = 18;  // flat cell index
  localparam int unsigned PlaneW = 13;  // grid_x * grid_y, at most 4096
  localparam int unsigned RowW   = AxisW + CoordW;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned NumSlots = 14;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [7:0] {
    REG_GRID_X = 8'd0,
    REG_GRID_Y = 8'd1,
    REG_GRID_Z = 8'd2,
    REG_TWO_D  = 8'd3
  } reg_idx_e;

  // Neighbor offsets of each stencil slot, one bit per slot.
  localparam logic [NumSlots-1:0] DxNeg = 14'b00_0010_0110_0110;
  localparam logic [NumSlots-1:0] DxPos = 14'b01_1001_0001_0000;
  localparam logic [NumSlots-1:0] DyNeg = 14'b00_0001_1011_1010;
  localparam logic [NumSlots-1:0] DyPos = 14'b00_1110_0000_0000;
  localparam logic [NumSlots-1:0] DzNeg = 14'b11_1111_1110_0000;

  typedef struct packed {
    logic [AxisW-1:0]  grid_x;
    logic [AxisW-1:0]  grid_y;
    logic [AxisW-1:0]  grid_z;
    logic              two_d;
    logic [PlaneW-1:0] plane;
  } cfg_t;

  typedef struct packed {
    logic [IndexW-1:0]   base;
    logic [NumSlots-1:0] mask;
    logic                bad;
  } qent_t;

endpackage

// ===== design/half_shell_neighbor_cell_stencil.sv =====
// Top level of the half-shell neighbor stencil: configuration registers and the two halves.
//
// Input side is a queue: an item (cell_x_i, cell_y_i, cell_z_i) is taken at a clock
// edge with push high and full low. Result side is a queue too: while empty is low the
// oldest result sits on cell_index_o, stencil_slot_o, last_o and bad_cell_o, and it is
// taken at an edge with pop high. Each item yields 1 to 14 results, the final one
// marked by last_o; a cell outside the domain yields one result with bad_cell_o set.
// On an idle block a taken item passes the front register, the queue and the back end's
// working register before its first result reaches the output register. The back end
// emits one result per cycle while the output register is free or being popped, and the
// front end and a two-entry queue take new items meanwhile. Configuration writes are always
// ready and must be made only while the block is idle. Reset empties all stages and loads
// grid sizes of 64 in 3D mode. When pop is held low, results wait in the output register,
// the back end stops, then the queue fills and full rises.
module half_shell_neighbor_cell_stencil (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [7:0]                 cfg_index_i,
  input  logic [7:0]                 cfg_data_i,
  input  logic                       push,
  output logic                       full,
  input  logic [hss_pkg::CoordW-1:0] cell_x_i,
  input  logic [hss_pkg::CoordW-1:0] cell_y_i,
  input  logic [hss_pkg::CoordW-1:0] cell_z_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [hss_pkg::IndexW-1:0] cell_index_o,
  output logic [hss_pkg::SlotW-1:0]  stencil_slot_o,
  output logic                       last_o,
  output logic                       bad_cell_o
);

  logic [hss_pkg::AxisW-1:0]  gx_q, gy_q, gz_q;
  logic                       two_d_q;
  logic [hss_pkg::PlaneW-1:0] plane_q;
  logic [hss_pkg::AxisW-1:0]  wval;
  logic [2*hss_pkg::AxisW-1:0] plane_wx, plane_wy;
  hss_pkg::cfg_t  cfg;
  hss_pkg::qent_t fq_wdata, fq_rdata;
  logic fq_wvalid, fq_full, fq_rvalid, fq_pop;

  assign cfg_ready_o = 1'b1;

  // Only the low AxisW bits of the data are used; grid sizes above the largest supported axis saturate.
  assign wval = (cfg_data_i[hss_pkg::AxisW-1:0] > hss_pkg::AxisW'(hss_pkg::MaxCellsPerAxis)) ?
                hss_pkg::AxisW'(hss_pkg::MaxCellsPerAxis) : cfg_data_i[hss_pkg::AxisW-1:0];

  // The layer size is updated in the same write as the grid size it depends on.
  assign plane_wx = (2*hss_pkg::AxisW)'(wval) * (2*hss_pkg::AxisW)'(gy_q);
  assign plane_wy = (2*hss_pkg::AxisW)'(gx_q) * (2*hss_pkg::AxisW)'(wval);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q    <= hss_pkg::AxisW'(hss_pkg::MaxCellsPerAxis);
      gy_q    <= hss_pkg::AxisW'(hss_pkg::MaxCellsPerAxis);
      gz_q    <= hss_pkg::AxisW'(hss_pkg::MaxCellsPerAxis);
      two_d_q <= 1'b0;
      plane_q <= hss_pkg::PlaneW'(hss_pkg::MaxCellsPerAxis * hss_pkg::MaxCellsPerAxis);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        hss_pkg::REG_GRID_X: begin
          gx_q    <= wval;
          plane_q <= plane_wx[hss_pkg::PlaneW-1:0];
        end
        hss_pkg::REG_GRID_Y: begin
          gy_q    <= wval;
          plane_q <= plane_wy[hss_pkg::PlaneW-1:0];
        end
        hss_pkg::REG_GRID_Z: gz_q    <= wval;
        hss_pkg::REG_TWO_D:  two_d_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.grid_x = gx_q;
  assign cfg.grid_y = gy_q;
  assign cfg.grid_z = gz_q;
  assign cfg.two_d  = two_d_q;
  assign cfg.plane  = plane_q;

  hss_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .push_i    (push),
    .full_o    (full),
    .cell_x_i  (cell_x_i),
    .cell_y_i  (cell_y_i),
    .cell_z_i  (cell_z_i),
    .q_valid_o (fq_wvalid),
    .q_full_i  (fq_full),
    .q_data_o  (fq_wdata)
  );

  hss_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_wvalid),
    .full_o     (fq_full),
    .wr_data_i  (fq_wdata),
    .rd_valid_o (fq_rvalid),
    .rd_pop_i   (fq_pop),
    .rd_data_o  (fq_rdata)
  );

  hss_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_valid_i      (fq_rvalid),
    .q_pop_o        (fq_pop),
    .q_data_i       (fq_rdata),
    .empty_o        (empty),
    .pop_i          (pop),
    .cell_index_o   (cell_index_o),
    .stencil_slot_o (stencil_slot_o),
    .last_o         (last_o),
    .bad_cell_o     (bad_cell_o)
  );

endmodule

// ===== design/hss_fifo.sv =====
// Short queue of classified items between the front and the back.
module hss_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          full_o,
  input  hss_pkg::qent_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_pop_i,
  output hss_pkg::qent_t rd_data_o
);

  hss_pkg::qent_t mem_q [hss_pkg::QueueDepth];
  logic [hss_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [hss_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [hss_pkg::QueueCntW-1:0] cnt_q, cnt_d;
  logic do_wr, do_rd;

  assign full_o     = (cnt_q == hss_pkg::QueueCntW'(hss_pkg::QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == hss_pkg::QueuePtrW'(hss_pkg::QueueDepth - 1)) ? '0 :
                 wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == hss_pkg::QueuePtrW'(hss_pkg::QueueDepth - 1)) ? '0 :
                 rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== design/hss_front.sv =====
// Front end: accepts cells, checks the domain, builds the slot mask and the base index.
module hss_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hss_pkg::cfg_t              cfg_i,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic [hss_pkg::CoordW-1:0] cell_x_i,
  input  logic [hss_pkg::CoordW-1:0] cell_y_i,
  input  logic [hss_pkg::CoordW-1:0] cell_z_i,
  output logic                       q_valid_o,
  input  logic                       q_full_i,
  output hss_pkg::qent_t             q_data_o
);

  logic accept, advance;
  logic okx, oky, okz, lo_x, lo_y, hi_x, hi_y, below, bad;
  logic [hss_pkg::NumSlots-1:0] mask;
  logic [hss_pkg::AxisW-1:0] x_ext, y_ext, z_ext;
  logic [hss_pkg::RowW-1:0] row;
  logic [hss_pkg::PlaneW+hss_pkg::CoordW-1:0] plane;

  logic                         vld_q;
  logic [hss_pkg::CoordW-1:0]   x_q;
  logic [hss_pkg::RowW-1:0]     row_q;
  logic [hss_pkg::IndexW-1:0]   plane_q;
  logic [hss_pkg::NumSlots-1:0] mask_q;
  logic                         bad_q;

  assign advance = vld_q && !q_full_i;
  assign full_o  = vld_q && q_full_i;
  assign accept  = push_i && !full_o;

  assign x_ext = hss_pkg::AxisW'(cell_x_i);
  assign y_ext = hss_pkg::AxisW'(cell_y_i);
  assign z_ext = hss_pkg::AxisW'(cell_z_i);

  always_comb begin
    okx   = (cell_x_i != '0) && (x_ext + 7'd2 <= cfg_i.grid_x);
    oky   = (cell_y_i != '0) && (y_ext + 7'd2 <= cfg_i.grid_y);
    okz   = cfg_i.two_d ? (cell_z_i == '0) :
            ((cell_z_i != '0) && (z_ext + 7'd2 <= cfg_i.grid_z));
    bad   = !(okx && oky && okz);
    lo_x  = (cell_x_i >= 6'd2);
    lo_y  = (cell_y_i >= 6'd2);
    hi_x  = (x_ext + 7'd3 <= cfg_i.grid_x);
    hi_y  = (y_ext + 7'd3 <= cfg_i.grid_y);
    below = !cfg_i.two_d && (cell_z_i >= 6'd2);

    mask[0]  = 1'b1;
    mask[1]  = lo_x && lo_y;
    mask[2]  = lo_x;
    mask[3]  = lo_y;
    mask[4]  = hi_x && lo_y;
    mask[5]  = below && lo_x && lo_y;
    mask[6]  = below && lo_x;
    mask[7]  = below && lo_y;
    mask[8]  = below && hi_x && lo_y;
    mask[9]  = below && lo_x && hi_y;
    mask[10] = below && hi_y;
    mask[11] = below && hi_x && hi_y;
    mask[12] = below && hi_x;
    mask[13] = below;
    if (bad) begin
      mask = hss_pkg::NumSlots'(1);
    end

    row   = hss_pkg::RowW'(cfg_i.grid_x) * hss_pkg::RowW'(cell_y_i);
    plane = (hss_pkg::PlaneW+hss_pkg::CoordW)'(cfg_i.plane) *
            (hss_pkg::PlaneW+hss_pkg::CoordW)'(cell_z_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (advance) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= cell_x_i;
      row_q   <= row;
      plane_q <= plane[hss_pkg::IndexW-1:0];
      mask_q  <= mask;
      bad_q   <= bad;
    end
  end

  assign q_valid_o     = vld_q;
  assign q_data_o.mask = mask_q;
  assign q_data_o.bad  = bad_q;
  assign q_data_o.base = bad_q ? '0 :
                         hss_pkg::IndexW'(x_q) + hss_pkg::IndexW'(row_q) + plane_q;

endmodule

// ===== design/hss_back.sv =====
// Back end: walks the slot mask of each item and emits one neighbor index per cycle while the output can take it.
module hss_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hss_pkg::cfg_t                cfg_i,
  input  logic                         q_valid_i,
  output logic                         q_pop_o,
  input  hss_pkg::qent_t               q_data_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [hss_pkg::IndexW-1:0]   cell_index_o,
  output logic [hss_pkg::SlotW-1:0]    stencil_slot_o,
  output logic                         last_o,
  output logic                         bad_cell_o
);

  logic                         act_q;
  logic [hss_pkg::NumSlots-1:0] mask_q;
  logic [hss_pkg::IndexW-1:0]   base_q;
  logic                         bad_q;

  logic                         ovld_q;
  logic [hss_pkg::IndexW-1:0]   oidx_q;
  logic [hss_pkg::SlotW-1:0]    oslot_q;
  logic                         olast_q;
  logic                         obad_q;

  logic out_rdy, emit, done, load;
  logic [hss_pkg::NumSlots-1:0] pick, rest;
  logic [hss_pkg::SlotW-1:0]    slot;
  logic [hss_pkg::IndexW-1:0]   gx_term, gxy_term, idx;

  assign out_rdy = !ovld_q || pop_i;
  assign emit    = act_q && out_rdy;

  // Lowest remaining slot goes out first, which is the stencil order.
  always_comb begin
    pick = mask_q & (~mask_q + 1'b1);
    rest = mask_q & ~pick;
    slot = '0;
    for (int i = 0; i < hss_pkg::NumSlots; i++) begin
      if (pick[i]) begin
        slot = hss_pkg::SlotW'(i);
      end
    end
    gx_term  = hss_pkg::IndexW'(cfg_i.grid_x);
    gxy_term = hss_pkg::IndexW'(cfg_i.plane);
    idx = base_q;
    if (|(pick & hss_pkg::DxNeg)) idx = idx - 1'b1;
    if (|(pick & hss_pkg::DxPos)) idx = idx + 1'b1;
    if (|(pick & hss_pkg::DyNeg)) idx = idx - gx_term;
    if (|(pick & hss_pkg::DyPos)) idx = idx + gx_term;
    if (|(pick & hss_pkg::DzNeg)) idx = idx - gxy_term;
  end

  assign done    = emit && (rest == '0);
  assign load    = q_valid_i && (!act_q || done);
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      if (load) begin
        act_q <= 1'b1;
      end else if (done) begin
        act_q <= 1'b0;
      end
      if (emit) begin
        ovld_q <= 1'b1;
      end else if (pop_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mask_q <= q_data_i.mask;
      base_q <= q_data_i.base;
      bad_q  <= q_data_i.bad;
    end else if (emit) begin
      mask_q <= rest;
    end
    if (emit) begin
      oidx_q  <= idx;
      oslot_q <= slot;
      olast_q <= (rest == '0);
      obad_q  <= bad_q;
    end
  end

  assign empty_o        = !ovld_q;
  assign cell_index_o   = oidx_q;
  assign stencil_slot_o = oslot_q;
  assign last_o         = olast_q;
  assign bad_cell_o     = obad_q;

endmodule
